// ===== sv/assert_macros.svh =====
// assertion macros used by the checker file qbpp_checker.sv
// no dependencies; include by bare file name
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: same-cycle check failed");

// antecedent implies consequent in the next cycle
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: next-cycle check failed");

`endif

// ===== sv/qbpp_pkg.sv =====
// shared types and constants for the queued beep pattern player
// no dependencies
package qbpp_pkg;

    localparam int DEFAULT_QUEUE_SLOTS = 16;

    // stream widths
    localparam int IN_TDATA_W  = 56;
    localparam int IN_TUSER_W  = 2;
    localparam int OUT_TDATA_W = 8;
    localparam int QCOUNT_W    = 5;

    // operation codes carried on s_tuser
    typedef enum logic [1:0] {
        OP_TICK    = 2'd0,
        OP_ENQUEUE = 2'd1,
        OP_RESET   = 2'd2
    } op_t;

    // one queued message, pattern in the low bits
    typedef struct packed {
        logic       beep;
        logic [7:0] period;
        logic [7:0] repeats;
        logic [31:0] pattern;
    } msg_t;

    localparam int MSG_W = $bits(msg_t);

    // controller to datapath
    typedef struct packed {
        logic exec;      // item transfer, apply operation
        logic load_msg;  // load next message from store read data
        logic capture;   // register result
    } ctrl_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic need_load; // current item ends a message and another is queued
    } dp_status_t;

endpackage

// ===== sv/qbpp_ctrl.sv =====
// controller for the beep pattern player: item sequencing and result valid
// depends on qbpp_pkg
module qbpp_ctrl (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    input  qbpp_pkg::dp_status_t   status,
    output qbpp_pkg::ctrl_cmd_t    cmd
);
    import qbpp_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_LOAD = 2'b10
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   accept;

    // take an item only when the result register is free at the next edge
    assign s_tready = (state_reg == ST_IDLE) && (!out_valid_reg || m_tready);
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = out_valid_reg;

    // commands to the datapath
    always_comb begin
        cmd.exec     = accept;
        cmd.load_msg = (state_reg == ST_LOAD);
        cmd.capture  = (accept && !status.need_load) || (state_reg == ST_LOAD);
    end

    // state sequencing
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept && status.need_load) begin
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD: begin
                state_next = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // result valid
    always_comb begin
        if (cmd.capture) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ===== sv/qbpp_dpath.sv =====
// datapath for the beep pattern player: message store, player registers, result
// depends on qbpp_pkg
module qbpp_dpath #(
    parameter int QUEUE_SLOTS = qbpp_pkg::DEFAULT_QUEUE_SLOTS
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic [qbpp_pkg::IN_TDATA_W-1:0]   s_tdata,
    input  logic [qbpp_pkg::IN_TUSER_W-1:0]   s_tuser,
    input  qbpp_pkg::ctrl_cmd_t               cmd,
    output qbpp_pkg::dp_status_t              status,
    output logic [qbpp_pkg::OUT_TDATA_W-1:0]  m_tdata
);
    import qbpp_pkg::*;

    localparam int SLOT_W = $clog2(QUEUE_SLOTS + 1);
    localparam int IDX_W  = (QUEUE_SLOTS > 1) ? $clog2(QUEUE_SLOTS) : 1;
    localparam logic [SLOT_W-1:0] QS_SLOT = SLOT_W'(QUEUE_SLOTS);

    // message store, read at the play slot whenever that slot is in range
    msg_t mem [QUEUE_SLOTS];
    msg_t rd_data_reg;

    logic [SLOT_W-1:0] write_slot_reg, write_slot_next;
    logic [SLOT_W-1:0] play_slot_reg, play_slot_next;
    logic [31:0]       active_pattern_reg, active_pattern_next;
    logic [31:0]       shift_pattern_reg, shift_pattern_next;
    logic [7:0]        repeats_left_reg, repeats_left_next;
    logic [7:0]        active_period_reg, active_period_next;
    logic [7:0]        ticks_left_reg, ticks_left_next;
    logic              active_beep_reg, active_beep_next;
    logic              buzzer_reg, buzzer_next;

    logic              res_buzzer_reg, res_playing_reg, res_accepted_reg;
    logic [QCOUNT_W-1:0] res_queued_reg;

    op_t         op;
    msg_t        in_msg;
    msg_t        load_src;
    logic        accepted;
    logic        mem_we;
    logic        rd_ok;
    logic [7:0]  ticks_dec;
    logic [7:0]  reps_dec;
    logic        tick_active;
    logic        period_end;
    logic        queue_done;

    assign op     = op_t'(s_tuser);
    assign in_msg = msg_t'(s_tdata[MSG_W-1:0]);
    assign rd_ok  = (play_slot_reg < QS_SLOT);

    // end-of-period decisions for a tick
    assign tick_active = (write_slot_reg != '0);
    assign ticks_dec   = ticks_left_reg - 8'd1;
    assign reps_dec    = repeats_left_reg - 8'd1;
    assign period_end  = (ticks_dec == 8'd0);
    assign queue_done  = (play_slot_reg >= write_slot_reg);

    assign status.need_load = (op == OP_TICK) && tick_active && period_end
                              && (reps_dec == 8'd0) && !queue_done;

    // message source for a load: input on first enqueue, store otherwise
    assign load_src = cmd.load_msg ? rd_data_reg : in_msg;

    // next-state logic of the player
    always_comb begin
        write_slot_next     = write_slot_reg;
        play_slot_next      = play_slot_reg;
        active_pattern_next = active_pattern_reg;
        shift_pattern_next  = shift_pattern_reg;
        repeats_left_next   = repeats_left_reg;
        active_period_next  = active_period_reg;
        ticks_left_next     = ticks_left_reg;
        active_beep_next    = active_beep_reg;
        buzzer_next         = buzzer_reg;
        accepted            = 1'b0;
        mem_we              = 1'b0;

        if (cmd.load_msg) begin
            active_pattern_next = load_src.pattern;
            shift_pattern_next  = load_src.pattern;
            repeats_left_next   = (load_src.repeats == 8'd0) ? 8'd1 : load_src.repeats;
            active_period_next  = load_src.period;
            ticks_left_next     = load_src.period;
            active_beep_next    = load_src.beep;
            play_slot_next      = play_slot_reg + SLOT_W'(1);
        end else if (cmd.exec) begin
            unique case (op)
                OP_TICK: begin
                    if (tick_active) begin
                        if (shift_pattern_reg[0]) begin
                            if (active_beep_reg) begin
                                buzzer_next = 1'b1;
                            end
                        end else begin
                            buzzer_next = 1'b0;
                        end
                        shift_pattern_next = shift_pattern_reg >> 1;
                        ticks_left_next    = ticks_dec;
                        if (period_end) begin
                            repeats_left_next = reps_dec;
                            if (reps_dec != 8'd0) begin
                                shift_pattern_next = active_pattern_reg;
                                ticks_left_next    = active_period_reg;
                            end else if (queue_done) begin
                                write_slot_next    = '0;
                                play_slot_next     = '0;
                                shift_pattern_next = '0;
                                buzzer_next        = 1'b0;
                            end
                        end
                    end
                end
                OP_ENQUEUE: begin
                    if (write_slot_reg < QS_SLOT) begin
                        accepted        = 1'b1;
                        mem_we          = 1'b1;
                        write_slot_next = write_slot_reg + SLOT_W'(1);
                        if (write_slot_reg == '0) begin
                            active_pattern_next = load_src.pattern;
                            shift_pattern_next  = load_src.pattern;
                            repeats_left_next   = (load_src.repeats == 8'd0) ? 8'd1
                                                                              : load_src.repeats;
                            active_period_next  = load_src.period;
                            ticks_left_next     = load_src.period;
                            active_beep_next    = load_src.beep;
                            play_slot_next      = SLOT_W'(1);
                        end
                    end
                end
                OP_RESET: begin
                    write_slot_next     = '0;
                    play_slot_next      = '0;
                    active_pattern_next = '0;
                    shift_pattern_next  = '0;
                    repeats_left_next   = '0;
                    active_period_next  = '0;
                    ticks_left_next     = '0;
                    active_beep_next    = 1'b0;
                end
                default: begin
                    // unused code: state unchanged
                end
            endcase
        end
    end

    // store write and registered read
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[write_slot_reg[IDX_W-1:0]] <= in_msg;
        end
        if (rd_ok) begin
            rd_data_reg <= mem[play_slot_reg[IDX_W-1:0]];
        end
    end

    // player registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            write_slot_reg     <= '0;
            play_slot_reg      <= '0;
            active_pattern_reg <= '0;
            shift_pattern_reg  <= '0;
            repeats_left_reg   <= '0;
            active_period_reg  <= '0;
            ticks_left_reg     <= '0;
            active_beep_reg    <= 1'b0;
            buzzer_reg         <= 1'b0;
        end else begin
            write_slot_reg     <= write_slot_next;
            play_slot_reg      <= play_slot_next;
            active_pattern_reg <= active_pattern_next;
            shift_pattern_reg  <= shift_pattern_next;
            repeats_left_reg   <= repeats_left_next;
            active_period_reg  <= active_period_next;
            ticks_left_reg     <= ticks_left_next;
            active_beep_reg    <= active_beep_next;
            buzzer_reg         <= buzzer_next;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            res_buzzer_reg   <= buzzer_next;
            res_playing_reg  <= (write_slot_next != '0);
            res_accepted_reg <= accepted;
            res_queued_reg   <= QCOUNT_W'(write_slot_next);
        end
    end

    assign m_tdata = {res_queued_reg, res_accepted_reg, res_playing_reg, res_buzzer_reg};

endmodule

// ===== sv/queued_beep_pattern_player_core.sv =====
// result: registered at the input transfer; a tick that moves on to the
// next queued message first passes through ST_LOAD for the registered store read
// throughput: one item per cycle, except a message change which holds s_tready low
// while in ST_LOAD; the input side stalls while a result waits unread
// reset: aresetn (synchronous) clears player state and buzzer; store contents are kept
module queued_beep_pattern_player_core #(
    parameter int QUEUE_SLOTS = qbpp_pkg::DEFAULT_QUEUE_SLOTS
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // pattern_bits[31:0], repeat_count[39:32], period_ticks[47:40], beep_enable[48]
    input  logic [qbpp_pkg::IN_TDATA_W-1:0]   s_tdata,
    // operation[1:0]
    input  logic [qbpp_pkg::IN_TUSER_W-1:0]   s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // buzzer_on[0], playing[1], enqueue_accepted[2], queued_messages[7:3]
    output logic [qbpp_pkg::OUT_TDATA_W-1:0]  m_tdata
);
    import qbpp_pkg::*;

    ctrl_cmd_t  cmd;
    dp_status_t status;

    qbpp_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    qbpp_dpath #(
        .QUEUE_SLOTS (QUEUE_SLOTS)
    ) u_dpath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .cmd      (cmd),
        .status   (status),
        .m_tdata  (m_tdata)
    );

endmodule

// ===== sv/qbpp_checker.sv =====
// port-level checks for the beep pattern player, bound to the top level
// depends on qbpp_pkg and assert_macros.svh
`include "assert_macros.svh"

module qbpp_checker (
    input logic                              aclk,
    input logic                              aresetn,
    input logic                              s_tvalid,
    input logic                              s_tready,
    input logic                              m_tvalid,
    input logic                              m_tready,
    input logic [qbpp_pkg::OUT_TDATA_W-1:0]  m_tdata
);
    import qbpp_pkg::*;

    logic s_xfer;
    assign s_xfer = s_tvalid && s_tready;

    // a stalled result keeps its value
    `ASSERT_NEXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

    // after a transfer either the result shows or the input side waits for a load
    `ASSERT_NEXT(a_result_follows, aclk, aresetn, s_xfer, m_tvalid || !s_tready)

    // an idle player reports an empty queue
    `ASSERT_SAME(a_idle_empty, aclk, aresetn, m_tvalid && !m_tdata[1], m_tdata[7:3] == 5'd0)

    // a stored message means the player is running
    `ASSERT_SAME(a_accept_plays, aclk, aresetn, m_tvalid && m_tdata[2], m_tdata[1])

endmodule

bind queued_beep_pattern_player_core qbpp_checker u_qbpp_checker (.*);
